>>> src/sorted_priority_queue_core_assert.svh
// Assertion macros used by the sorted priority queue core.
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/spq_pkg.sv
// Package with widths, codes and types of the sorted priority queue.
`default_nettype none
package spq_pkg;

    localparam int PRIO_W              = 8;
    localparam int DATA_W              = 32;
    localparam int FILL_W              = 5;
    localparam int DEFAULT_QUEUE_DEPTH = 16;

    // Operation codes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // Per-cell control, built by the top level for each cell.
    typedef struct packed {
        logic insert;    // an insert is applied this cycle
        logic remove;    // a remove is applied this cycle
        logic occupied;  // cell holds a stored entry
        logic at_tail;   // cell is the first free slot
        logic shift_in;  // left neighbor moves right into this cell
    } t_cell_ctrl;

endpackage
`default_nettype wire

>>> src/spq_if.sv
// Handshake interfaces for the request and result channels.
`default_nettype none
interface spq_req_if import spq_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [PRIO_W-1:0]        priority_req;
    logic signed [DATA_W-1:0] payload;

    modport source (output valid, output op, output priority_req, output payload,
                    input ready);
    modport sink   (input valid, input op, input priority_req, input payload,
                    output ready);
endinterface

interface spq_rsp_if import spq_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] out_payload;
    logic [PRIO_W-1:0]        out_priority;
    logic [FILL_W-1:0]        fill_level;

    modport source (output valid, output status, output out_payload, output out_priority,
                    output fill_level, input ready);
    modport sink   (input valid, input status, input out_payload, input out_priority,
                    input fill_level, output ready);
endinterface
`default_nettype wire

>>> src/sorted_priority_queue_core.sv
// A result is registered at the clock edge that accepts its request transaction.
// Throughput: one transaction per cycle while the result side keeps taking results.
// Every cell updates in parallel, so an insert or a remove moves all entries together.
// Reset clears the fill count and the result valid flag; slots and result fields keep old values.
// Ready drops only while an unaccepted result is held.
`default_nettype none
`include "sorted_priority_queue_core_assert.svh"
module sorted_priority_queue_core import spq_pkg::*; #(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    spq_req_if.sink    i_req,
    spq_rsp_if.source  o_rsp
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    t_status           r_status;
    logic [DATA_W-1:0] r_out_data;
    logic [PRIO_W-1:0] r_out_prio;
    logic [FILL_W-1:0] r_fill;

    logic              accept;
    logic              is_empty;
    logic              is_full;
    logic              do_insert;
    logic              do_remove;
    t_status           n_status;
    logic [CNT_W+FILL_W-1:0] fill_ext;

    t_cell_ctrl        cell_ctrl [QUEUE_DEPTH];
    logic [PRIO_W-1:0] cell_prio [QUEUE_DEPTH];
    logic [DATA_W-1:0] cell_data [QUEUE_DEPTH];
    logic              cell_gt   [QUEUE_DEPTH];

    // Request handshake and operation decode.
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign is_empty    = (r_count == '0);
    assign is_full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign do_insert   = accept && (i_req.op == OP_INSERT) && !is_full;
    assign do_remove   = accept && (i_req.op == OP_REMOVE) && !is_empty;

    // Chain of cells, each told whether it is occupied or the first free slot.
    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        logic [PRIO_W-1:0] left_prio;
        logic [DATA_W-1:0] left_data;
        logic [PRIO_W-1:0] right_prio;
        logic [DATA_W-1:0] right_data;
        logic              left_gt;

        if (gi == 0) begin : g_head
            assign left_prio = i_req.priority_req;
            assign left_data = i_req.payload;
            assign left_gt   = 1'b0;
        end else begin : g_body
            assign left_prio = cell_prio[gi-1];
            assign left_data = cell_data[gi-1];
            assign left_gt   = cell_gt[gi-1];
        end

        if (gi == QUEUE_DEPTH - 1) begin : g_tail
            assign right_prio = cell_prio[gi];
            assign right_data = cell_data[gi];
        end else begin : g_inner
            assign right_prio = cell_prio[gi+1];
            assign right_data = cell_data[gi+1];
        end

        assign cell_ctrl[gi] = '{
            insert:   do_insert,
            remove:   do_remove,
            occupied: (CNT_W'(gi) < r_count),
            at_tail:  (CNT_W'(gi) == r_count),
            shift_in: left_gt
        };

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (cell_ctrl[gi]),
            .i_req_prio   (i_req.priority_req),
            .i_req_data   (i_req.payload),
            .i_left_prio  (left_prio),
            .i_left_data  (left_data),
            .i_right_prio (right_prio),
            .i_right_data (right_data),
            .o_prio       (cell_prio[gi]),
            .o_data       (cell_data[gi]),
            .o_gt         (cell_gt[gi])
        );
    end

    // Next fill count and result status.
    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        if (do_insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_remove) begin
            n_count = r_count - CNT_W'(1);
        end
        if (i_req.op == OP_REMOVE && is_empty) begin
            n_status = ST_UNDERFLOW;
        end else if (i_req.op == OP_INSERT && is_full) begin
            n_status = ST_FULL;
        end
    end

    assign fill_ext = {{FILL_W{1'b0}}, n_count};

    // Fill count and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status   <= n_status;
            r_out_data <= do_remove ? cell_data[0] : '0;
            r_out_prio <= do_remove ? cell_prio[0] : '0;
            r_fill     <= fill_ext[FILL_W-1:0];
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.out_payload  = r_out_data;
    assign o_rsp.out_priority = r_out_prio;
    assign o_rsp.fill_level   = r_fill;

    // Checks on the queue's own bookkeeping.
    `SPQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH),
        "fill count above queue depth")
    `SPQ_ASSERT_NEXT(a_remove_count, do_remove, r_count == $past(r_count) - CNT_W'(1),
        "remove did not lower the fill count")
    `SPQ_ASSERT_NOW(a_head_order, r_count >= CNT_W'(2), cell_prio[0] >= cell_prio[1],
        "head entry outranked by the second entry")
    `SPQ_ASSERT_NOW(a_error_zero, r_out_valid && r_status != ST_OK,
        r_out_data == '0 && r_out_prio == '0, "failed operation returned data")

endmodule
`default_nettype wire

>>> src/spq_cell.sv
// One slot of the sorted queue chain: holds an entry and trades it with its neighbors.
`default_nettype none
module spq_cell import spq_pkg::*; (
    input  wire logic              i_clk,
    input  wire t_cell_ctrl        i_ctrl,
    input  wire logic [PRIO_W-1:0] i_req_prio,
    input  wire logic [DATA_W-1:0] i_req_data,
    input  wire logic [PRIO_W-1:0] i_left_prio,
    input  wire logic [DATA_W-1:0] i_left_data,
    input  wire logic [PRIO_W-1:0] i_right_prio,
    input  wire logic [DATA_W-1:0] i_right_data,
    output logic [PRIO_W-1:0]      o_prio,
    output logic [DATA_W-1:0]      o_data,
    output logic                   o_gt
);

    logic [PRIO_W-1:0] r_prio;
    logic [DATA_W-1:0] r_data;
    logic [PRIO_W-1:0] n_prio;
    logic [DATA_W-1:0] n_data;

    // The new entry outranks the stored one; equal priorities keep the older entry first.
    assign o_gt = i_ctrl.occupied && (i_req_prio > r_prio);

    // Next contents: shift left on remove, shift right or take the new entry on insert.
    always_comb begin
        n_prio = r_prio;
        n_data = r_data;
        if (i_ctrl.remove) begin
            n_prio = i_right_prio;
            n_data = i_right_data;
        end else if (i_ctrl.insert && (i_ctrl.occupied || i_ctrl.at_tail)) begin
            if (i_ctrl.shift_in) begin
                n_prio = i_left_prio;
                n_data = i_left_data;
            end else if (o_gt || i_ctrl.at_tail) begin
                n_prio = i_req_prio;
                n_data = i_req_data;
            end
        end
    end

    // Entry storage; contents are meaningful only below the fill count.
    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_data <= n_data;
    end

    assign o_prio = r_prio;
    assign o_data = r_data;

endmodule
`default_nettype wire

>>> test/sorted_priority_queue_core_tb.sv
// Self-checking testbench for the sorted priority queue core, with a shadow queue predictor.
`default_nettype none
module sorted_priority_queue_core_tb;
    import spq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH    = DEFAULT_QUEUE_DEPTH;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 8;

    // One expected result transaction.
    typedef struct {
        t_status                  status;
        logic signed [DATA_W-1:0] head_data;
        logic [PRIO_W-1:0]        head_prio;
        logic [FILL_W-1:0]        fill;
    } t_queue_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    spq_req_if req_if ();
    spq_rsp_if rsp_if ();

    sorted_priority_queue_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // Shadow copy of the queue contents, kept in descending priority order.
    logic [PRIO_W-1:0]        shadow_prio [QUEUE_DEPTH];
    logic signed [DATA_W-1:0] shadow_data [QUEUE_DEPTH];
    int                       shadow_count = 0;

    t_queue_result awaited_results [$];
    t_queue_result oldest_result;
    int            error_count  = 0;
    int            idle_cycles  = 0;
    bit            sender_gaps  = 1'b1;
    bit            sink_stalls  = 1'b1;
    int            sink_run     = 0;
    int            sink_hold    = 0;

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 80) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Applies one request to the shadow queue and returns the result it should produce.
    function automatic t_queue_result apply_to_shadow_queue(logic op, logic [PRIO_W-1:0] prio,
                                                            logic signed [DATA_W-1:0] data);
        t_queue_result res;
        int            pos;
        res.status    = ST_OK;
        res.head_data = '0;
        res.head_prio = '0;
        if (op == OP_REMOVE) begin
            if (shadow_count == 0) begin
                res.status = ST_UNDERFLOW;
            end else begin
                res.head_prio = shadow_prio[0];
                res.head_data = shadow_data[0];
                for (int i = 1; i < shadow_count; i++) begin
                    shadow_prio[i-1] = shadow_prio[i];
                    shadow_data[i-1] = shadow_data[i];
                end
                shadow_count--;
            end
        end else if (shadow_count >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
        end else begin
            // The new entry goes ahead of the first entry with a strictly lower priority.
            pos = shadow_count;
            for (int i = 0; i < shadow_count; i++) begin
                if (prio > shadow_prio[i]) begin
                    pos = i;
                    break;
                end
            end
            for (int i = shadow_count; i > pos; i--) begin
                shadow_prio[i] = shadow_prio[i-1];
                shadow_data[i] = shadow_data[i-1];
            end
            shadow_prio[pos] = prio;
            shadow_data[pos] = data;
            shadow_count++;
        end
        res.fill = FILL_W'(shadow_count);
        return res;
    endfunction

    // Sends one request transaction; valid stays high afterwards for a back-to-back follower.
    task automatic issue_request(logic op, logic [PRIO_W-1:0] prio,
                                 logic signed [DATA_W-1:0] data);
        int gap;
        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.op           <= op;
        req_if.priority_req <= prio;
        req_if.payload      <= data;
        do @(posedge i_clk); while (!req_if.ready);
        awaited_results.push_back(apply_to_shadow_queue(op, prio, data));
    endtask

    // Drops valid and waits until every expected result has arrived.
    task automatic hold_until_drained();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    // Result side: bursts of ready with random stalls in between.
    always @(posedge i_clk) begin
        if (sink_run == 0 && sink_hold == 0) begin
            sink_run  = $urandom_range(1, 20);
            sink_hold = sink_stalls ? pick_gap() : 0;
        end
        if (sink_hold > 0) begin
            sink_hold--;
            rsp_if.ready <= 1'b0;
        end else begin
            sink_run--;
            rsp_if.ready <= 1'b1;
        end
    end

    // Compare each result transaction against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result: status %0d payload %0d priority %0d fill %0d",
                       rsp_if.status, rsp_if.out_payload, rsp_if.out_priority,
                       rsp_if.fill_level);
                error_count++;
            end else begin
                oldest_result = awaited_results.pop_front();
                if (rsp_if.status !== oldest_result.status) begin
                    $error("status: expected %0d, actual %0d",
                           oldest_result.status, rsp_if.status);
                    error_count++;
                end
                if (rsp_if.out_payload !== oldest_result.head_data) begin
                    $error("out_payload: expected %0d, actual %0d",
                           oldest_result.head_data, rsp_if.out_payload);
                    error_count++;
                end
                if (rsp_if.out_priority !== oldest_result.head_prio) begin
                    $error("out_priority: expected %0d, actual %0d",
                           oldest_result.head_prio, rsp_if.out_priority);
                    error_count++;
                end
                if (rsp_if.fill_level !== oldest_result.fill) begin
                    $error("fill_level: expected %0d, actual %0d",
                           oldest_result.fill, rsp_if.fill_level);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sorted_priority_queue_core verification failed");
            $finish;
        end
    end

    // A remove from the empty queue reports underflow.
    task automatic test_remove_when_empty();
        issue_request(OP_REMOVE, 8'd0, '0);
    endtask

    // Fill every slot with extreme priorities, ties and extreme payloads.
    task automatic test_fill_to_capacity();
        logic [PRIO_W-1:0]        prio_table [16] = '{8'd255, 8'd0, 8'd128, 8'd128,
                                                      8'd255, 8'd0, 8'd1, 8'd254,
                                                      8'd128, 8'd64, 8'd200, 8'd0,
                                                      8'd255, 8'd127, 8'd128, 8'd63};
        logic signed [DATA_W-1:0] data_table [4] = '{32'sh7FFF_FFFF, 32'sh8000_0000,
                                                     32'sh0000_0000, 32'shFFFF_FFFF};
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            issue_request(OP_INSERT, prio_table[i % 16],
                          (i < 4) ? data_table[i] : $signed($urandom()));
        end
    endtask

    // An insert into the full queue is dropped and reports full.
    task automatic test_insert_when_full();
        issue_request(OP_INSERT, 8'd255, 32'sh1234_5678);
    endtask

    // Pop a few heads to see priority order and the age order among ties.
    task automatic test_pop_head_order();
        repeat (4) issue_request(OP_REMOVE, 8'd0, '0);
    endtask

    // Mixed traffic kept around mid fill, pausing now and then until all results are back.
    task automatic test_random_traffic(int count);
        int                threshold;
        logic [PRIO_W-1:0] prio;
        for (int n = 0; n < count; n++) begin
            if (n % 150 == 149) hold_until_drained();
            threshold = (shadow_count < 4) ? 75 : (shadow_count > 12) ? 25 : 50;
            prio = ($urandom_range(0, 9) < 3) ? PRIO_W'($urandom_range(0, 3))
                                              : PRIO_W'($urandom());
            issue_request(($urandom_range(0, 99) < threshold) ? OP_INSERT : OP_REMOVE,
                          prio, $signed($urandom()));
        end
    endtask

    // Fill past capacity, then drain past empty, over and over.
    task automatic test_fill_drain_cycles(int rounds);
        logic [PRIO_W-1:0] prio;
        for (int r = 0; r < rounds; r++) begin
            while (shadow_count < QUEUE_DEPTH) begin
                prio = r[0] ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom());
                issue_request(OP_INSERT, prio, $signed($urandom()));
            end
            repeat ($urandom_range(1, 3)) issue_request(OP_INSERT, PRIO_W'($urandom()),
                                                        $signed($urandom()));
            while (shadow_count > 0) issue_request(OP_REMOVE, PRIO_W'($urandom()),
                                                   $signed($urandom()));
            repeat ($urandom_range(1, 2)) issue_request(OP_REMOVE, PRIO_W'($urandom()),
                                                        $signed($urandom()));
        end
    endtask

    // Full rate on both sides: no sender gaps and no result stalls.
    task automatic test_full_rate(int count);
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
        test_random_traffic(count);
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
    endtask

    // Main sequence.
    initial begin
        req_if.valid        = 1'b0;
        req_if.op           = OP_INSERT;
        req_if.priority_req = '0;
        req_if.payload      = '0;
        rsp_if.ready        = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_remove_when_empty();
        test_fill_to_capacity();
        test_insert_when_full();
        test_pop_head_order();
        test_random_traffic(800);
        test_fill_drain_cycles(8);
        test_full_rate(250);
        test_random_traffic(150);

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && awaited_results.size() == 0) begin
            $display("sorted_priority_queue_core verification clean");
        end else begin
            $display("sorted_priority_queue_core verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
